// File: rtl/pst_pkg.sv
// Shared constants and types for the process isolation slot table.
package pst_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int PID_W          = 32;
  localparam int ASID_W         = 32;
  localparam int CLASS_W        = 8;
  localparam int IDX_OUT_W      = 6;
  localparam int ENTRY_W        = CLASS_W + ASID_W + PID_W;

  // Result status codes
  localparam logic STATUS_BOUND = 1'b0;
  localparam logic STATUS_FULL  = 1'b1;

  // Finished bind result, handed from the sequencer to the output register
  typedef struct packed {
    logic                 status;
    logic [IDX_OUT_W-1:0] slot_index;
    logic [PID_W-1:0]     pid;
    logic [ASID_W-1:0]    asid;
  } pst_res_t;

endpackage

// File: rtl/pst_req_if.sv
// Bind request channel: valid/ready plus the request payload.
interface pst_req_if;
  logic                        valid;
  logic                        ready;
  logic [pst_pkg::PID_W-1:0]   proc_id;
  logic [pst_pkg::ASID_W-1:0]  space_id;
  logic [pst_pkg::CLASS_W-1:0] isolation_class;

  modport source (output valid, output proc_id, output space_id,
                  output isolation_class, input ready);
  modport sink   (input valid, input proc_id, input space_id,
                  input isolation_class, output ready);
endinterface

// File: rtl/pst_rsp_if.sv
// Bind result channel: valid/ready plus the result payload.
interface pst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [pst_pkg::IDX_OUT_W-1:0] slot_index;
  logic [pst_pkg::PID_W-1:0]     bound_proc_id;
  logic [pst_pkg::ASID_W-1:0]    bound_space_id;

  modport source (output valid, output status, output slot_index,
                  output bound_proc_id, output bound_space_id, input ready);
  modport sink   (input valid, input status, input slot_index,
                  input bound_proc_id, input bound_space_id, output ready);
endinterface

// File: rtl/process_isolation_slot_table.sv
// Top level of the process isolation slot table: sequencer plus result register.
//
//   channel  dir  fields
//   req      in   proc_id[32], space_id[32], isolation_class[8]
//   rsp      out  status[1], slot_index[6], bound_proc_id[32],
//                 bound_space_id[32]
//
// A bind scans the filled slots (fill = slots in use) from its request beat, then
// goes through the write state to its result in the output register; a hit ends
// the scan early and a full table skips the write. The scan reads one slot per
// cycle from the single slot RAM read port. Valid slots are always 0..fill-1, so
// reset clears only the state and the fill count and needs no clearing pass.
// req.ready is high only while no bind is in progress; a finished result waits in
// the output register and the next request is taken once it has moved there.
module process_isolation_slot_table #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF
) (
  input  logic     clk,
  input  logic     rst,
  pst_req_if.sink  req,
  pst_rsp_if.source rsp
);

  logic              res_valid;
  logic              res_take;
  pst_pkg::pst_res_t res;
  logic              out_valid;
  pst_pkg::pst_res_t out_res;

  pst_ctrl #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register takes a result whenever it is empty or being drained
  assign res_take = res_valid && (!out_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res <= res;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_res.status;
  assign rsp.slot_index     = out_res.slot_index;
  assign rsp.bound_proc_id  = out_res.pid;
  assign rsp.bound_space_id = out_res.asid;

endmodule

// File: rtl/pst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pst_ram #(
  parameter int WIDTH = pst_pkg::ENTRY_W,
  parameter int DEPTH = pst_pkg::SLOT_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pst_ctrl.sv
// Scan sequencer: walks the filled slots through one comparator, then writes the slot unless the table is full.
module pst_ctrl #(
  parameter int SLOT_COUNT = pst_pkg::SLOT_COUNT_DEF
) (
  input  logic             clk,
  input  logic             rst,
  pst_req_if.sink          req,
  output logic             res_valid,
  input  logic             res_take,
  output pst_pkg::pst_res_t res
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_WRITE = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                      state, state_next;
  logic [CNT_W-1:0]            fill, fill_next;   // slots 0..fill-1 are valid
  logic [CNT_W-1:0]            cnt, cnt_next;     // next slot to read
  logic                        pend, pend_next;   // read data due this cycle
  logic [IDX_W-1:0]            pend_idx, pend_idx_next;
  logic [IDX_W-1:0]            sel, sel_next;
  logic                        full, full_next;
  logic [pst_pkg::PID_W-1:0]   req_pid, req_pid_next;
  logic [pst_pkg::ASID_W-1:0]  req_asid, req_asid_next;
  logic [pst_pkg::CLASS_W-1:0] req_cls, req_cls_next;

  logic                        we;
  logic [pst_pkg::ENTRY_W-1:0] rd_data;
  logic                        rd_more;
  logic                        match;

  // Slot store: {class, address space, process id}
  pst_ram #(
    .WIDTH (pst_pkg::ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (sel),
    .wdata ({req_cls, req_asid, req_pid}),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (rd_data)
  );

  // Shared key comparator
  assign rd_more = (cnt < fill);
  assign match   = pend && (rd_data[pst_pkg::PID_W-1:0] == req_pid);

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // Sequencer
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    cnt_next      = cnt;
    pend_next     = pend;
    pend_idx_next = pend_idx;
    sel_next      = sel;
    full_next     = full;
    req_pid_next  = req_pid;
    req_asid_next = req_asid;
    req_cls_next  = req_cls;
    we            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          req_pid_next  = req.proc_id;
          req_asid_next = req.space_id;
          req_cls_next  = req.isolation_class;
          cnt_next      = '0;
          pend_next     = 1'b0;
          state_next    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (match) begin
          sel_next   = pend_idx;
          full_next  = 1'b0;
          state_next = S_WRITE;
        end else if (!rd_more && !pend) begin
          if (fill == CNT_W'(SLOT_COUNT)) begin
            full_next  = 1'b1;
            state_next = S_DONE;
          end else begin
            // no match: take the lowest free slot
            sel_next   = fill[IDX_W-1:0];
            fill_next  = fill + 1'b1;
            full_next  = 1'b0;
            state_next = S_WRITE;
          end
        end else begin
          pend_next     = rd_more;
          pend_idx_next = cnt[IDX_W-1:0];
          if (rd_more) begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      S_WRITE: begin
        we         = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    pend     <= pend_next;
    pend_idx <= pend_idx_next;
    sel      <= sel_next;
    full     <= full_next;
    req_pid  <= req_pid_next;
    req_asid <= req_asid_next;
    req_cls  <= req_cls_next;
  end

  // Result; slot index and ids zeroed when the table is full
  always_comb begin
    res.status     = full ? pst_pkg::STATUS_FULL : pst_pkg::STATUS_BOUND;
    res.slot_index = full ? '0
                          : pst_pkg::IDX_OUT_W'({{pst_pkg::IDX_OUT_W{1'b0}}, sel});
    res.pid        = full ? '0 : req_pid;
    res.asid       = full ? '0 : req_asid;
  end

  // Fill count never passes the table size
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(SLOT_COUNT))
    else $error("fill count exceeds slot count");

  // Fill grows by one, only on the way to a slot write
  a_fill_step: assert property (@(posedge clk) disable iff (rst)
    (fill != $past(fill)) |-> (fill == $past(fill) + 1'b1) && (state == S_WRITE))
    else $error("fill count moved unexpectedly");

  // A written slot is always inside the filled region
  a_sel_filled: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE) |-> (CNT_W'(sel) < fill))
    else $error("write outside filled slots");

  // Table full is only reported when every slot is taken
  a_full_real: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && full) |-> (fill == CNT_W'(SLOT_COUNT)))
    else $error("full reported with free slots");

endmodule
